// ===== sv/clbfp_pkg.sv =====
// shared types, codes and byte classes for the code/length/body frame parser
package clbfp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BLEN_W     = 24;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned EVENT_W    = 3;
  localparam int unsigned S_TDATA_W  = 8;
  localparam int unsigned M_TDATA_W  = 40;

  localparam logic [BYTE_W-1:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [BYTE_W-1:0] CHAR_SPACE      = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB        = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_CR         = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_ZERO       = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE       = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_A    = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z    = 8'h5A;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_A    = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_Z    = 8'h7A;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_WITH_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY_LENGTH   = 1'b1;

  typedef enum logic [EVENT_W-1:0] {
    EV_SKIP  = 3'd0,
    EV_CODE  = 3'd1,
    EV_DIGIT = 3'd2,
    EV_BODY  = 3'd3,
    EV_ERROR = 3'd4
  } clbfp_event_e;

  typedef struct packed {
    clbfp_event_e       event_res;
    logic [BYTE_W-1:0]  byte_out;
    logic               code_end;
    logic               message_end;
    logic [BLEN_W-1:0]  body_length;
    logic               incomplete;
  } clbfp_result_t;

  function automatic logic is_ws(input logic [BYTE_W-1:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_letter(input logic [BYTE_W-1:0] c);
    return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
           (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
  endfunction

endpackage

// ===== sv/clbfp_parser.sv =====
// parse state machine: phase, length accumulator, body counter and config registers
module clbfp_parser import clbfp_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [BYTE_W-1:0]     data_byte_i,
  input  logic                  chunk_end_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output clbfp_result_t         result_o
);

  localparam int unsigned CMP_W = (LENGTH_BITS > BLEN_W) ? LENGTH_BITS : BLEN_W;
  localparam int unsigned ACC_W = LENGTH_BITS + 4;

  typedef enum logic [2:0] {
    PH_BEFORE_CODE   = 3'd0,
    PH_CODE          = 3'd1,
    PH_BEFORE_LENGTH = 3'd2,
    PH_LENGTH        = 3'd3,
    PH_BEFORE_BODY   = 3'd4,
    PH_BODY          = 3'd5
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [LENGTH_BITS-1:0]  len_q, len_d;
  logic [LENGTH_BITS-1:0]  cnt_q, cnt_d;
  logic                    mode_q;
  logic [BLEN_W-1:0]       max_q;

  logic [LENGTH_BITS-1:0]  acc_base;
  logic [ACC_W-1:0]        acc_sum;
  logic [LENGTH_BITS-1:0]  len_sat;
  logic [LENGTH_BITS-1:0]  cnt_inc;
  logic [CMP_W-1:0]        len_ext;
  logic [CMP_W-1:0]        max_ext;
  logic                    c_ws, c_digit, c_letter;
  phase_e                  start_phase;

  clbfp_event_e            ev;
  logic [BYTE_W-1:0]       echo;
  logic                    cend, mend;
  logic [BLEN_W-1:0]       blen;

  assign c_ws     = is_ws(data_byte_i);
  assign c_digit  = is_digit(data_byte_i);
  assign c_letter = is_letter(data_byte_i);

  assign start_phase = mode_q ? PH_BEFORE_LENGTH : PH_BEFORE_CODE;

  // times ten plus digit, saturating at the top of the length range
  assign acc_base = (phase_q == PH_BEFORE_LENGTH) ? '0 : len_q;
  assign acc_sum  = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
                  + ACC_W'(data_byte_i[3:0]);
  assign len_sat  = (acc_sum[ACC_W-1:LENGTH_BITS] != '0) ? '1 : acc_sum[LENGTH_BITS-1:0];

  assign cnt_inc = cnt_q + 1'b1;
  assign len_ext = CMP_W'(len_q);
  assign max_ext = CMP_W'(max_q);

  always_comb begin
    ev      = EV_SKIP;
    echo    = '0;
    cend    = 1'b0;
    mend    = 1'b0;
    blen    = '0;
    phase_d = phase_q;
    len_d   = len_q;
    cnt_d   = cnt_q;

    unique case (phase_q)
      PH_BEFORE_CODE: begin
        if (c_ws) begin
          ev = EV_SKIP;
        end else if (c_letter) begin
          ev      = EV_CODE;
          echo    = data_byte_i;
          phase_d = PH_CODE;
        end else begin
          ev = EV_ERROR;
        end
      end
      PH_CODE: begin
        if (c_letter || c_digit || data_byte_i == CHAR_UNDERSCORE) begin
          ev   = EV_CODE;
          echo = data_byte_i;
        end else if (c_ws) begin
          cend    = 1'b1;
          phase_d = PH_BEFORE_LENGTH;
        end else begin
          ev = EV_ERROR;
        end
      end
      PH_BEFORE_LENGTH: begin
        if (c_ws) begin
          ev = EV_SKIP;
        end else if (c_digit) begin
          ev      = EV_DIGIT;
          len_d   = len_sat;
          phase_d = PH_LENGTH;
        end else begin
          ev = EV_ERROR;
        end
      end
      PH_LENGTH: begin
        if (c_digit) begin
          ev    = EV_DIGIT;
          len_d = len_sat;
        end else if (c_ws) begin
          blen = len_ext[BLEN_W-1:0];
          if (len_ext > max_ext) begin
            ev = EV_ERROR;
          end else if (len_q == '0) begin
            mend = 1'b1;
          end else begin
            cnt_d   = '0;
            phase_d = PH_BEFORE_BODY;
          end
        end else begin
          ev = EV_ERROR;
        end
      end
      PH_BEFORE_BODY, PH_BODY: begin
        if (phase_q == PH_BEFORE_BODY && c_ws) begin
          ev = EV_SKIP;
        end else begin
          ev      = EV_BODY;
          echo    = data_byte_i;
          phase_d = PH_BODY;
          cnt_d   = cnt_inc;
          if (cnt_inc >= len_q) begin
            mend = 1'b1;
            blen = len_ext[BLEN_W-1:0];
          end
        end
      end
      default: begin
        ev = EV_ERROR;
      end
    endcase

    // rearm after an error or a finished message
    if (ev == EV_ERROR) begin
      phase_d = PH_BEFORE_CODE;
      len_d   = '0;
      cnt_d   = '0;
    end else if (mend) begin
      phase_d = start_phase;
      len_d   = '0;
      cnt_d   = '0;
    end
  end

  always_comb begin
    result_o.event_res   = ev;
    result_o.byte_out    = echo;
    result_o.code_end    = cend;
    result_o.message_end = mend;
    result_o.body_length = blen;
    result_o.incomplete  = chunk_end_i && !mend && (ev != EV_ERROR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_BEFORE_CODE;
      len_q   <= '0;
      cnt_q   <= '0;
      mode_q  <= 1'b0;
      max_q   <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_START_WITH_LENGTH: begin
          mode_q  <= cfg_data_i[0];
          phase_q <= cfg_data_i[0] ? PH_BEFORE_LENGTH : PH_BEFORE_CODE;
          len_q   <= '0;
          cnt_q   <= '0;
        end
        CFG_MAX_BODY_LENGTH: begin
          max_q <= cfg_data_i[BLEN_W-1:0];
        end
        default: begin
          max_q <= max_q;
        end
      endcase
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== sv/code_length_body_frame_parser.sv =====
// top level of the code/length/body frame parser
// each result beat is registered in the output stage before it appears on the master side
// one byte per cycle unless the skid is full; phase and length updates are combinational
// a two-entry output stage (register plus skid) keeps s_axis_tready independent of m_axis_tready
// reset (rst_ni low, asynchronous): expect-code phase, counters cleared, reply mode off,
// max body length all ones, output stage empty
module code_length_body_frame_parser import clbfp_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave side
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic                  s_axis_tlast,   // chunk_end
  // master side
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [7:0] byte_out, [8] code_end,
                                                // [32:9] body_length, [33] incomplete
  output logic [EVENT_W-1:0]    m_axis_tuser,   // [2:0] event_res
  output logic                  m_axis_tlast,   // message_end
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic          in_beat, out_beat;
  clbfp_result_t res;
  clbfp_result_t out_q, skid_q;
  logic          out_valid_q, skid_valid_q;

  assign s_axis_tready = !skid_valid_q;
  assign cfg_ready_o   = 1'b1;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_beat      = m_axis_tvalid && m_axis_tready;

  clbfp_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_beat),
    .data_byte_i (s_axis_tdata[BYTE_W-1:0]),
    .chunk_end_i (s_axis_tlast),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_beat) begin
        out_valid_q  <= skid_valid_q || in_beat;
        skid_valid_q <= 1'b0;
      end else if (in_beat) begin
        if (out_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_beat) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_beat) begin
      if (out_valid_q) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.event_res;
  assign m_axis_tlast  = out_q.message_end;
  assign m_axis_tdata  = {6'b000000, out_q.incomplete, out_q.body_length,
                          out_q.code_end, out_q.byte_out};

endmodule

// ===== tb/sv/code_length_body_frame_parser_tb.sv =====
// self-checking testbench for the code/length/body frame parser
`timescale 1ns / 100ps

module code_length_body_frame_parser_tb;
  import clbfp_pkg::*;

  localparam longint unsigned LEN_CEIL = (64'd1 << BLEN_W) - 1;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SEG_BYTES = 80;

  typedef enum logic [2:0] {
    WAIT_CODE, IN_CODE, WAIT_LENGTH, IN_LENGTH, WAIT_BODY, IN_BODY
  } parse_phase_e;

  typedef enum logic [2:0] {
    K_WS, K_DIGIT, K_LETTER, K_UNDERSCORE, K_OTHER
  } byte_kind_e;

  class parse_scoreboard;
    bit                 reply_mode;
    logic [BLEN_W-1:0]  max_len;
    parse_phase_e       phase;
    logic [BLEN_W-1:0]  len_acc;
    logic [BLEN_W-1:0]  body_seen;
    clbfp_result_t      expected_events[$];
    int unsigned        mismatches;

    function new();
      reply_mode = 1'b0;
      max_len = '1;
      mismatches = 0;
      restart(WAIT_CODE);
    endfunction

    function void restart(parse_phase_e p);
      phase = p;
      len_acc = '0;
      body_seen = '0;
    endfunction

    function parse_phase_e home();
      return reply_mode ? WAIT_LENGTH : WAIT_CODE;
    endfunction

    function byte_kind_e kind_of(logic [BYTE_W-1:0] c);
      if (c inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]}) return K_WS;
      if (c inside {[CHAR_ZERO:CHAR_NINE]}) return K_DIGIT;
      if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z], [CHAR_LOWER_A:CHAR_LOWER_Z]}) return K_LETTER;
      if (c == CHAR_UNDERSCORE) return K_UNDERSCORE;
      return K_OTHER;
    endfunction

    // decimal accumulate, pinned at the all-ones length
    function logic [BLEN_W-1:0] push_digit(logic [BLEN_W-1:0] acc, logic [BYTE_W-1:0] c);
      longint unsigned v;
      v = 64'(acc) * 10 + 64'(c - CHAR_ZERO);
      return (v > LEN_CEIL) ? BLEN_W'(LEN_CEIL) : v[BLEN_W-1:0];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_START_WITH_LENGTH: begin
          reply_mode = d[0];
          restart(home());
        end
        CFG_MAX_BODY_LENGTH: max_len = d[BLEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [BYTE_W-1:0] c, logic last);
      clbfp_result_t r;
      byte_kind_e k;
      r = '0;
      r.event_res = EV_SKIP;
      k = kind_of(c);
      case (phase)
        WAIT_CODE: begin
          if (k == K_LETTER) begin
            r.event_res = EV_CODE;
            r.byte_out = c;
            phase = IN_CODE;
          end else if (k != K_WS) begin
            r.event_res = EV_ERROR;
          end
        end
        IN_CODE: begin
          if (k inside {K_LETTER, K_DIGIT, K_UNDERSCORE}) begin
            r.event_res = EV_CODE;
            r.byte_out = c;
          end else if (k == K_WS) begin
            r.code_end = 1'b1;
            phase = WAIT_LENGTH;
          end else begin
            r.event_res = EV_ERROR;
          end
        end
        WAIT_LENGTH: begin
          if (k == K_DIGIT) begin
            r.event_res = EV_DIGIT;
            len_acc = push_digit('0, c);
            phase = IN_LENGTH;
          end else if (k != K_WS) begin
            r.event_res = EV_ERROR;
          end
        end
        IN_LENGTH: begin
          if (k == K_DIGIT) begin
            r.event_res = EV_DIGIT;
            len_acc = push_digit(len_acc, c);
          end else if (k == K_WS) begin
            // length is reported on the closing whitespace, error or not
            r.body_length = len_acc;
            if (len_acc > max_len) begin
              r.event_res = EV_ERROR;
            end else if (len_acc == 0) begin
              r.message_end = 1'b1;
            end else begin
              body_seen = '0;
              phase = WAIT_BODY;
            end
          end else begin
            r.event_res = EV_ERROR;
          end
        end
        WAIT_BODY, IN_BODY: begin
          if (!(phase == WAIT_BODY && k == K_WS)) begin
            r.event_res = EV_BODY;
            r.byte_out = c;
            phase = IN_BODY;
            body_seen++;
            if (body_seen >= len_acc) begin
              r.message_end = 1'b1;
              r.body_length = len_acc;
            end
          end
        end
        default: r.event_res = EV_ERROR;
      endcase
      if (r.event_res == EV_ERROR) restart(WAIT_CODE);
      else if (r.message_end) restart(home());
      r.incomplete = last && !r.message_end && (r.event_res != EV_ERROR);
      expected_events.push_back(r);
    endfunction

    function void check_beat(clbfp_result_t got);
      clbfp_result_t want;
      bit bad;
      if (expected_events.size() == 0) begin
        $error("unexpected result beat: event_res %0d", got.event_res);
        mismatches++;
        return;
      end
      want = expected_events.pop_front();
      bad = 1'b0;
      if (got.event_res !== want.event_res) begin
        $error("event_res: expected %0d, actual %0d", want.event_res, got.event_res);
        bad = 1'b1;
      end
      if (got.byte_out !== want.byte_out) begin
        $error("byte_out: expected %0h, actual %0h", want.byte_out, got.byte_out);
        bad = 1'b1;
      end
      if (got.code_end !== want.code_end) begin
        $error("code_end: expected %0d, actual %0d", want.code_end, got.code_end);
        bad = 1'b1;
      end
      if (got.message_end !== want.message_end) begin
        $error("message_end: expected %0d, actual %0d", want.message_end, got.message_end);
        bad = 1'b1;
      end
      if (got.body_length !== want.body_length) begin
        $error("body_length: expected %0d, actual %0d", want.body_length, got.body_length);
        bad = 1'b1;
      end
      if (got.incomplete !== want.incomplete) begin
        $error("incomplete: expected %0d, actual %0d", want.incomplete, got.incomplete);
        bad = 1'b1;
      end
      if (bad) mismatches++;
    endfunction

    function int unsigned outstanding();
      return expected_events.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [EVENT_W-1:0]    m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  parse_scoreboard sb = new();
  clbfp_result_t   seen_beat;
  logic [8:0]      stream_q[$];   // {chunk_end, data_byte}
  int unsigned     send_idle_pct = 30;
  int unsigned     recv_idle_pct = 50;
  int unsigned     bytes_sent = 0;
  int unsigned     stall_cycles = 0;

  code_length_body_frame_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_beat.event_res   = clbfp_event_e'(m_axis_tuser);
      seen_beat.byte_out    = m_axis_tdata[7:0];
      seen_beat.code_end    = m_axis_tdata[8];
      seen_beat.body_length = m_axis_tdata[32:9];
      seen_beat.incomplete  = m_axis_tdata[33];
      seen_beat.message_end = m_axis_tlast;
      sb.check_beat(seen_beat);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void add_byte(input logic [BYTE_W-1:0] c);
    stream_q.push_back({($urandom_range(99) < 8), c});
  endfunction

  function automatic void queue_text(input string s, input logic last);
    int i;
    for (i = 0; i < s.len(); i++) stream_q.push_back({last && (i == s.len() - 1), s[i]});
  endfunction

  function automatic logic [BYTE_W-1:0] pick_ws();
    if ($urandom_range(0, 5) == 0) return CHAR_SPACE;
    return CHAR_TAB + BYTE_W'($urandom_range(0, 4));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_letter();
    if ($urandom_range(0, 1) == 1) return CHAR_UPPER_A + BYTE_W'($urandom_range(0, 25));
    return CHAR_LOWER_A + BYTE_W'($urandom_range(0, 25));
  endfunction

  // one message shaped from where the parser stands now; broken ones get a byte replaced
  function automatic void gen_frame(input bit broken);
    int unsigned first, pos, len, roll, i;
    bit huge;
    string digits;
    parse_phase_e p;
    logic [BYTE_W-1:0] c;
    first = stream_q.size();
    p = sb.phase;
    huge = 1'b0;
    // mid-token, or awaiting a length outside reply mode: a stray punctuation byte forces the return to the code phase
    if (p == IN_CODE || p == IN_LENGTH || (p == WAIT_LENGTH && !sb.reply_mode)) begin
      stream_q.push_back({1'b0, 8'h21});
      p = WAIT_CODE;
    end
    if (p == WAIT_CODE || p == WAIT_LENGTH) repeat ($urandom_range(0, 2)) add_byte(pick_ws());
    if (p == WAIT_CODE) begin
      add_byte(pick_letter());
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(0, 3))
          0: add_byte(CHAR_ZERO + BYTE_W'($urandom_range(0, 9)));
          1: add_byte(CHAR_UNDERSCORE);
          default: add_byte(pick_letter());
        endcase
      end
      repeat ($urandom_range(1, 2)) add_byte(pick_ws());
    end
    roll = $urandom_range(99);
    if (roll < 10) len = 0;
    else if (roll < 85 && roll >= 70) len = $urandom_range(13, 60);
    else if (roll >= 85 && sb.max_len != '1) huge = 1'b1;
    else len = $urandom_range(1, 12);
    if ($urandom_range(0, 4) == 0) add_byte(CHAR_ZERO);
    if (huge) begin
      add_byte(CHAR_ZERO + BYTE_W'($urandom_range(1, 9)));
      repeat ($urandom_range(8, 10)) add_byte(CHAR_ZERO + BYTE_W'($urandom_range(0, 9)));
    end else begin
      digits = $sformatf("%0d", len);
      for (i = 0; i < digits.len(); i++) add_byte(digits[i]);
    end
    repeat ($urandom_range(1, 2)) add_byte(pick_ws());
    if (!huge && len != 0 && len <= sb.max_len) begin
      // a leading whitespace byte would be skipped, not counted
      do c = BYTE_W'($urandom_range(0, 255));
      while (c inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]});
      add_byte(c);
      repeat (len - 1) add_byte(BYTE_W'($urandom_range(0, 255)));
    end
    if (broken) begin
      pos = $urandom_range(first, stream_q.size() - 1);
      stream_q[pos] = {stream_q[pos][8], BYTE_W'($urandom_range(0, 255))};
    end
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] c, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_byte(c, last);
    bytes_sent++;
  endtask

  task automatic send_stream();
    logic [8:0] beat;
    while (stream_q.size() != 0) begin
      beat = stream_q.pop_front();
      send_byte(beat[7:0], beat[8]);
    end
  endtask

  // hold the input side until every result is back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic program_regs(input bit mode, input logic [CFG_DATA_W-1:0] max_word);
    logic [CFG_DATA_W-1:0] mode_word;
    bit mode_first;
    int k;
    mode_word = CFG_DATA_W'($urandom);
    mode_word[0] = mode;
    mode_first = $urandom_range(0, 1);
    cfg_valid_i <= 1'b1;
    for (k = 0; k < 2; k++) begin
      if ((k == 0) == mode_first) begin
        cfg_index_i <= CFG_START_WITH_LENGTH;
        cfg_data_i  <= mode_word;
      end else begin
        cfg_index_i <= CFG_MAX_BODY_LENGTH;
        cfg_data_i  <= max_word;
      end
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.write_reg(cfg_index_i, cfg_data_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int ph, seg, c;
    int unsigned seg_start, roll;
    logic [CFG_DATA_W-1:0] max_word;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every whitespace kind up front, chunk boundary on the first byte
    stream_q.push_back({1'b1, CHAR_SPACE});
    for (c = CHAR_TAB; c <= CHAR_CR; c++) stream_q.push_back({1'b0, BYTE_W'(c)});
    queue_text("a_Z9 0\tz 2 ", 1'b0);
    stream_q.push_back({1'b0, 8'h00});
    stream_q.push_back({1'b1, 8'hFF});
    stream_q.push_back({1'b1, 8'h80});
    send_stream();
    settle();
    // length above the limit
    program_regs(1'b0, 24'd3);
    queue_text("k 4 ", 1'b0);
    send_stream();
    settle();
    // reply message without code
    program_regs(1'b1, '1);
    queue_text("1 x", 1'b0);
    send_stream();

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 30; recv_idle_pct = 50; end
        1: begin send_idle_pct = 50; recv_idle_pct = 30; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (seg = 0; seg < 4; seg++) begin
        settle();
        case (seg)
          0: max_word = '1;
          1: max_word = CFG_DATA_W'($urandom_range(1, 30));
          2: max_word = '0;
          default: max_word = CFG_DATA_W'($urandom);
        endcase
        program_regs(((seg + ph) % 2) == 1, max_word);
        seg_start = bytes_sent;
        while (bytes_sent - seg_start < SEG_BYTES) begin
          roll = $urandom_range(99);
          if (roll < 12) repeat ($urandom_range(1, 4)) add_byte(BYTE_W'($urandom_range(0, 255)));
          else gen_frame(roll < 27);
          send_stream();
        end
      end
    end

    settle();
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
